// File: rtl/screen_edge_zone_detect_assert.svh
// ----------------------------------------------------------------------------
// screen_edge_zone_detect_assert.svh
// Assertion macros shared by the checker of the edge zone detector.
// ----------------------------------------------------------------------------
`ifndef SCREEN_EDGE_ZONE_DETECT_ASSERT_SVH
`define SCREEN_EDGE_ZONE_DETECT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEZD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SEZD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SEZD_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sezd_pkg.sv
// ----------------------------------------------------------------------------
// sezd_pkg
// Types, codes and constants of the screen edge zone detector.
// ----------------------------------------------------------------------------
package sezd_pkg;

  // Monitor table depth and the index and count widths that follow from it.
  localparam int MAX_MON = 8;
  localparam int IDX_W   = (MAX_MON > 1) ? $clog2(MAX_MON) : 1;
  localparam int CNT_W   = $clog2(MAX_MON + 1);

  // Command queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_EDGES_ONLY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THICKNESS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_SIZE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ENABLE_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_COUNT    = 3'd5;

  localparam logic [11:0] EDGE_THICKNESS_RST = 12'd32;
  localparam logic [11:0] CORNER_SIZE_RST    = 12'd160;

  // Item kinds.
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_CURSOR = 1'b1;

  // Zone codes, in test priority order.
  localparam logic [2:0] ZONE_TOPLEFT     = 3'd0;
  localparam logic [2:0] ZONE_TOPRIGHT    = 3'd1;
  localparam logic [2:0] ZONE_BOTTOMLEFT  = 3'd2;
  localparam logic [2:0] ZONE_BOTTOMRIGHT = 3'd3;
  localparam logic [2:0] ZONE_LEFT        = 3'd4;
  localparam logic [2:0] ZONE_RIGHT       = 3'd5;
  localparam logic [2:0] ZONE_TOP         = 3'd6;
  localparam logic [2:0] ZONE_BOTTOM      = 3'd7;

  // Pixel conversion: ceil(v * dpi / 1536) = floor((v * dpi + 1535) / 512 / 3),
  // with the division by three done as a multiply by 43691 / 2^17.
  localparam logic [21:0] PIX_ROUND = 22'd1535;
  localparam logic [15:0] RECIP3    = 16'd43691;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [9:0]         dpi;
  } mon_entry_t;

  typedef struct packed {
    logic               is_cursor;
    logic [IDX_W-1:0]   slot;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    mon_entry_t         entry;
  } cmd_t;

  typedef struct packed {
    logic             detect_enable;
    logic             outer_edges_only;
    logic [11:0]      edge_thickness;
    logic [11:0]      corner_size;
    logic [7:0]       zone_mask;
    logic [CNT_W-1:0] count;
  } cfg_t;

endpackage

// File: rtl/sezd_fifo.sv
// ----------------------------------------------------------------------------
// sezd_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module sezd_fifo
  import sezd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t             q_mem [Q_DEPTH];
  logic [Q_PTR_W:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W:0] rd_ptr_r, rd_ptr_nxt;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[Q_PTR_W] != rd_ptr_r[Q_PTR_W]) &&
                 (wr_ptr_r[Q_PTR_W-1:0] == rd_ptr_r[Q_PTR_W-1:0]);
  assign pop_data = q_mem[rd_ptr_r[Q_PTR_W-1:0]];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push && !full) begin
      wr_ptr_nxt = wr_ptr_r + (Q_PTR_W+1)'(1);
    end
    if (pop && !empty) begin
      rd_ptr_nxt = rd_ptr_r + (Q_PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q_mem[wr_ptr_r[Q_PTR_W-1:0]] <= push_data;
    end
  end

endmodule

// File: rtl/sezd_front.sv
// ----------------------------------------------------------------------------
// sezd_front
// Input stage: takes items, sorts loads from cursor samples, drops loads
// aimed past the table, and hands commands to the queue.
// ----------------------------------------------------------------------------
module sezd_front
  import sezd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [2:0]  in_slot,
  input  logic [15:0] in_cursor_x,
  input  logic [15:0] in_cursor_y,
  input  logic [15:0] in_bound_left,
  input  logic [15:0] in_bound_top,
  input  logic [15:0] in_bound_right,
  input  logic [15:0] in_bound_bottom,
  input  logic [9:0]  in_monitor_dpi,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_data
);

  logic cmd_valid_r, cmd_valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic take;
  logic keep;

  assign in_stall = cmd_valid_r && q_full;
  assign take     = in_valid && !in_stall;
  assign q_push   = cmd_valid_r && !q_full;
  assign q_data   = cmd_r;

  always_comb begin
    cmd_nxt.is_cursor    = (in_kind == KIND_CURSOR);
    cmd_nxt.slot         = IDX_W'(in_slot);
    cmd_nxt.cx           = $signed(in_cursor_x);
    cmd_nxt.cy           = $signed(in_cursor_y);
    cmd_nxt.entry.left   = $signed(in_bound_left);
    cmd_nxt.entry.top    = $signed(in_bound_top);
    cmd_nxt.entry.right  = $signed(in_bound_right);
    cmd_nxt.entry.bottom = $signed(in_bound_bottom);
    cmd_nxt.entry.dpi    = in_monitor_dpi;
    // A load for a slot past the table is taken and then forgotten.
    keep = (in_kind == KIND_CURSOR) || (int'(in_slot) < MAX_MON);

    cmd_valid_nxt = cmd_valid_r;
    if (take) begin
      cmd_valid_nxt = keep;
    end else if (q_push) begin
      cmd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// File: rtl/sezd_back.sv
// ----------------------------------------------------------------------------
// sezd_back
// Execution engine: owns the monitor table, scans it for the cursor's
// monitor, converts the zone sizes to pixels, in outer-edges mode checks for
// shared sides, and picks the first enabled zone.
// ----------------------------------------------------------------------------
module sezd_back
  import sezd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_hit,
  output logic [2:0] out_zone,
  output logic [2:0] out_monitor_index
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FIND   = 6'b000010,
    ST_CONV   = 6'b000100,
    ST_OUTER  = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  function automatic logic signed [16:0] sx17(input logic signed [15:0] v);
    return {v[15], v};
  endfunction

  function automatic logic holds(input mon_entry_t e,
                                 input logic signed [16:0] x,
                                 input logic signed [16:0] y);
    return (x >= sx17(e.left)) && (x < sx17(e.right)) &&
           (y >= sx17(e.top)) && (y < sx17(e.bottom));
  endfunction

  function automatic logic [11:0] pix_fix(input logic [28:0] p);
    logic [11:0] q;
    q = p[28:17];
    return (q == '0) ? 12'd1 : q;
  endfunction

  state_t state_r, state_nxt;

  // Table memory with a registered read port.
  mon_entry_t       mem [MAX_MON];
  mon_entry_t       rd_q_r;
  logic             mem_we;

  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [2:0]       step_r, step_nxt;
  logic signed [15:0] cx_r, cx_nxt, cy_r, cy_nxt;
  mon_entry_t       sel_r, sel_nxt;
  logic [IDX_W-1:0] sel_idx_r, sel_idx_nxt;
  logic [28:0]      prod_r, prod_nxt;
  logic [11:0]      th_r, th_nxt, cs_r, cs_nxt;
  logic [3:0]       side_ok_r, side_ok_nxt;   // left, right, top, bottom
  logic             res_hit_r, res_hit_nxt;
  logic [2:0]       res_zone_r, res_zone_nxt;
  logic [2:0]       res_idx_r, res_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic [2:0]       out_zone_r, out_zone_nxt;
  logic [2:0]       out_idx_r, out_idx_nxt;

  logic [12:0]      mul_a;
  logic [15:0]      mul_b;
  logic [28:0]      mul_p;
  logic [21:0]      rnd_sum;
  logic             last_entry;

  logic signed [17:0] cx18, cy18, l18, t18, r18, b18, cs18, th18;
  logic signed [16:0] px_l, px_r, px_t, px_b;
  logic [7:0]         cand;
  logic               found;

  assign mul_p      = mul_a * mul_b;
  assign rnd_sum    = prod_r[21:0] + PIX_ROUND;
  assign last_entry = (CNT_W'(cnt_r) + CNT_W'(1)) == cfg.count;

  assign q_pop             = (state_r == ST_IDLE) && !q_empty;
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_zone          = out_zone_r;
  assign out_monitor_index = out_idx_r;

  always_comb begin
    cx18 = {{2{cx_r[15]}}, cx_r};
    cy18 = {{2{cy_r[15]}}, cy_r};
    l18  = {{2{sel_r.left[15]}}, sel_r.left};
    t18  = {{2{sel_r.top[15]}}, sel_r.top};
    r18  = {{2{sel_r.right[15]}}, sel_r.right};
    b18  = {{2{sel_r.bottom[15]}}, sel_r.bottom};
    cs18 = $signed({6'b0, cs_r});
    th18 = $signed({6'b0, th_r});
    // The pixels just beyond each side of the selected monitor.
    px_l = sx17(sel_r.left) - 17'sd1;
    px_r = sx17(sel_r.right);
    px_t = sx17(sel_r.top) - 17'sd1;
    px_b = sx17(sel_r.bottom);

    cand[ZONE_TOPLEFT]     = side_ok_r[0] && side_ok_r[2] &&
                             (cx18 < l18 + cs18) && (cy18 < t18 + cs18);
    cand[ZONE_TOPRIGHT]    = side_ok_r[1] && side_ok_r[2] &&
                             (cx18 >= r18 - cs18) && (cy18 < t18 + cs18);
    cand[ZONE_BOTTOMLEFT]  = side_ok_r[0] && side_ok_r[3] &&
                             (cx18 < l18 + cs18) && (cy18 >= b18 - cs18);
    cand[ZONE_BOTTOMRIGHT] = side_ok_r[1] && side_ok_r[3] &&
                             (cx18 >= r18 - cs18) && (cy18 >= b18 - cs18);
    cand[ZONE_LEFT]        = side_ok_r[0] && (cx18 < l18 + th18);
    cand[ZONE_RIGHT]       = side_ok_r[1] && (cx18 >= r18 - th18);
    cand[ZONE_TOP]         = side_ok_r[2] && (cy18 < t18 + th18);
    cand[ZONE_BOTTOM]      = side_ok_r[3] && (cy18 >= b18 - th18);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    step_nxt      = step_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    sel_nxt       = sel_r;
    sel_idx_nxt   = sel_idx_r;
    prod_nxt      = prod_r;
    th_nxt        = th_r;
    cs_nxt        = cs_r;
    side_ok_nxt   = side_ok_r;
    res_hit_nxt   = res_hit_r;
    res_zone_nxt  = res_zone_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    out_zone_nxt  = out_zone_r;
    out_idx_nxt   = out_idx_r;
    mem_we        = 1'b0;
    mul_a         = {1'b0, cfg.edge_thickness};
    mul_b         = {6'b0, sel_r.dpi};
    found         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_cmd.is_cursor) begin
            cx_nxt       = q_cmd.cx;
            cy_nxt       = q_cmd.cy;
            res_hit_nxt  = 1'b0;
            res_zone_nxt = '0;
            res_idx_nxt  = '0;
            cnt_nxt      = '0;
            if (!cfg.detect_enable || (cfg.count == '0)) begin
              state_nxt = ST_EMIT;
            end else begin
              state_nxt = ST_FIND;
            end
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_FIND: begin
        // rd_q_r holds table entry cnt_r here.
        if (holds(rd_q_r, sx17(cx_r), sx17(cy_r))) begin
          sel_nxt     = rd_q_r;
          sel_idx_nxt = cnt_r;
          step_nxt    = '0;
          state_nxt   = ST_CONV;
        end else if (last_entry) begin
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_CONV: begin
        // One shared multiplier: product, then the reciprocal of three,
        // first for the edge thickness and then for the corner size.
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd0: begin
            prod_nxt = mul_p;
          end
          3'd1: begin
            mul_a    = rnd_sum[21:9];
            mul_b    = RECIP3;
            prod_nxt = mul_p;
          end
          3'd2: begin
            th_nxt   = pix_fix(prod_r);
            mul_a    = {1'b0, cfg.corner_size};
            prod_nxt = mul_p;
          end
          3'd3: begin
            mul_a    = rnd_sum[21:9];
            mul_b    = RECIP3;
            prod_nxt = mul_p;
          end
          default: begin
            cs_nxt      = pix_fix(prod_r);
            side_ok_nxt = 4'b1111;
            cnt_nxt     = '0;
            state_nxt   = cfg.outer_edges_only ? ST_OUTER : ST_DECIDE;
          end
        endcase
      end
      ST_OUTER: begin
        if (cnt_r != sel_idx_r) begin
          if (holds(rd_q_r, px_l, sx17(cy_r))) side_ok_nxt[0] = 1'b0;
          if (holds(rd_q_r, px_r, sx17(cy_r))) side_ok_nxt[1] = 1'b0;
          if (holds(rd_q_r, sx17(cx_r), px_t)) side_ok_nxt[2] = 1'b0;
          if (holds(rd_q_r, sx17(cx_r), px_b)) side_ok_nxt[3] = 1'b0;
        end
        if (last_entry) begin
          state_nxt = ST_DECIDE;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_DECIDE: begin
        for (int z = 0; z < 8; z++) begin
          if (!found && cand[z] && cfg.zone_mask[z]) begin
            found        = 1'b1;
            res_hit_nxt  = 1'b1;
            res_zone_nxt = 3'(z);
            res_idx_nxt  = 3'(sel_idx_r);
          end
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_zone_nxt  = res_zone_r;
          out_idx_nxt   = res_idx_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    step_r     <= step_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    sel_r      <= sel_nxt;
    sel_idx_r  <= sel_idx_nxt;
    prod_r     <= prod_nxt;
    th_r       <= th_nxt;
    cs_r       <= cs_nxt;
    side_ok_r  <= side_ok_nxt;
    res_hit_r  <= res_hit_nxt;
    res_zone_r <= res_zone_nxt;
    res_idx_r  <= res_idx_nxt;
    out_hit_r  <= out_hit_nxt;
    out_zone_r <= out_zone_nxt;
    out_idx_r  <= out_idx_nxt;
  end

  // The read address follows the next scan index, so in the scan states rd_q_r
  // holds the entry that cnt_r points at.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_cmd.slot] <= q_cmd.entry;
    end
    rd_q_r <= mem[cnt_nxt];
  end

endmodule

// File: rtl/screen_edge_zone_detect.sv
// ----------------------------------------------------------------------------
// screen_edge_zone_detect
// Top level: configuration registers, input front, command queue and
// zone detection engine.
// ----------------------------------------------------------------------------
// Load items write one monitor rectangle and its DPI into an eight-entry
// table; each cursor sample gives one result with a hit flag, the zone and
// the monitor index. Items pass a front register and a two-entry queue, so
// the input keeps taking items while the engine works. The engine reads the
// table through one registered port, one entry per cycle. A cursor sample
// gives a miss without a scan when detection is off or the monitor count is
// zero; else the engine scans the table up to the first entry that holds it,
// over at most monitor_count entries capped at eight, and gives a miss if
// none does. Outer-edges mode adds a scan of the neighboring monitors. The
// zone size conversion shares one multiplier. A result that waits on a
// stalled output holds the engine for as long as the stall lasts.
// Configuration writes are always accepted and take effect at once; write
// them only while idle.
// ----------------------------------------------------------------------------
module screen_edge_zone_detect
  import sezd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [2:0]  in_slot,
  input  logic [15:0] in_cursor_x,
  input  logic [15:0] in_cursor_y,
  input  logic [15:0] in_bound_left,
  input  logic [15:0] in_bound_top,
  input  logic [15:0] in_bound_right,
  input  logic [15:0] in_bound_bottom,
  input  logic [9:0]  in_monitor_dpi,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [2:0]  out_zone,
  output logic [2:0]  out_monitor_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  logic        detect_enable_r;
  logic        outer_edges_only_r;
  logic [11:0] edge_thickness_r;
  logic [11:0] corner_size_r;
  logic [7:0]  zone_mask_r;
  logic [3:0]  monitor_count_r;
  cfg_t        cfg;

  logic        q_push, q_full, q_pop, q_empty;
  cmd_t        q_in, q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_enable_r    <= 1'b0;
      outer_edges_only_r <= 1'b0;
      edge_thickness_r   <= EDGE_THICKNESS_RST;
      corner_size_r      <= CORNER_SIZE_RST;
      zone_mask_r        <= '0;
      monitor_count_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DETECT_ENABLE:    detect_enable_r    <= cfg_data[0];
        CFG_OUTER_EDGES_ONLY: outer_edges_only_r <= cfg_data[0];
        CFG_EDGE_THICKNESS:   edge_thickness_r   <= cfg_data;
        CFG_CORNER_SIZE:      corner_size_r      <= cfg_data;
        CFG_ZONE_ENABLE_MASK: zone_mask_r        <= cfg_data[7:0];
        CFG_MONITOR_COUNT:    monitor_count_r    <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.detect_enable    = detect_enable_r;
    cfg.outer_edges_only = outer_edges_only_r;
    cfg.edge_thickness   = edge_thickness_r;
    cfg.corner_size      = corner_size_r;
    cfg.zone_mask        = zone_mask_r;
    // A count above the table depth scans the whole table.
    if (int'(monitor_count_r) > MAX_MON) begin
      cfg.count = CNT_W'(MAX_MON);
    end else begin
      cfg.count = CNT_W'(monitor_count_r);
    end
  end

  sezd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_slot         (in_slot),
    .in_cursor_x     (in_cursor_x),
    .in_cursor_y     (in_cursor_y),
    .in_bound_left   (in_bound_left),
    .in_bound_top    (in_bound_top),
    .in_bound_right  (in_bound_right),
    .in_bound_bottom (in_bound_bottom),
    .in_monitor_dpi  (in_monitor_dpi),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_in)
  );

  sezd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  sezd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .q_empty           (q_empty),
    .q_cmd             (q_out),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_zone          (out_zone),
    .out_monitor_index (out_monitor_index)
  );

endmodule

// File: rtl/sezd_checker.sv
// ----------------------------------------------------------------------------
// sezd_checker
// Port-level checks of the edge zone detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "screen_edge_zone_detect_assert.svh"

module sezd_checker
  import sezd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_kind,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_hit,
  input logic [2:0] out_zone,
  input logic [2:0] out_monitor_index
);

  // Cursor samples taken whose result has not yet been transferred.
  logic [3:0] pend_r, pend_nxt;
  logic       cur_in, res_out;

  assign cur_in  = in_valid && !in_stall && (in_kind == KIND_CURSOR);
  assign res_out = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (cur_in && !res_out) begin
      pend_nxt = pend_r + 4'd1;
    end else if (res_out && !cur_in) begin
      pend_nxt = pend_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `SEZD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hit) && $stable(out_zone) && $stable(out_monitor_index), "result changed while stalled")
  `SEZD_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, out_zone == '0 && out_monitor_index == '0, "miss result carries nonzero fields")
  `SEZD_ASSERT_NOW(a_no_spurious, out_valid, pend_r != '0, "result without a pending cursor sample")
  `SEZD_ASSERT_RST(a_reset_idle, !rst_n, !out_valid && !in_stall, "reset did not clear the channels")

endmodule

bind screen_edge_zone_detect sezd_checker u_sezd_checker (.*);
